[hdl/gams_pkg.sv]
// Shared types and constants for the graph adjacency matrix store.
// No dependencies; used by graph_adjacency_matrix_store.
package gams_pkg;

    // Default and largest supported vertex capacity
    localparam int MAX_VERTICES_DEF = 16;
    localparam int MAX_VERTICES_TOP = 64;

    // Index that means "no vertex"
    localparam logic signed [6:0] NO_INDEX = -7'sd1;

    typedef enum logic [2:0] {
        MODE_ADD_VERTEX = 3'd0,
        MODE_DEL_VERTEX = 3'd1,
        MODE_ADD_EDGE   = 3'd2,
        MODE_DEL_EDGE   = 3'd3,
        MODE_FIND       = 3'd4,
        MODE_LIST_ADJ   = 3'd5,
        MODE_IS_ADJ     = 3'd6,
        MODE_UNKNOWN    = 3'd7
    } mode_t;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_BAD_INDEX = 2'd1,
        STAT_FULL      = 2'd2,
        STAT_BAD_MODE  = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISP,
        ST_EDGE_A,
        ST_EDGE_B,
        ST_SCAN,
        ST_ADJ_RD,
        ST_LIST_LD,
        ST_LIST_NEXT,
        ST_LIST_EMIT,
        ST_REM,
        ST_RESP
    } state_t;

endpackage

[hdl/graph_adjacency_matrix_store.sv]
// Undirected graph store: vertex value memory plus adjacency row memory,
// driven by a sequencer that reads, modifies and writes back one entry a cycle.
// Depends on gams_pkg.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+---------------------------------------
//   in      | to block  | in_valid/in_stall  | mode vertex_value other_value index_a/b
//   out     | from block| out_valid/out_stall| status found_index neighbor_value
//           |           |                    | neighbor_valid adjacent vertex_count last
//
// One item at a time; each memory has one read and one write port, which sets the pace.
// Work grows with the vertex count for remove, find and is adjacent (which scans twice, once
// per value), and with the neighbor count for list; add vertex, edge, bad index and unknown
// mode do not.
// Reset clears the vertex count and control state only; no clearing pass is needed.
// A stalled output holds the sequencer; the next item is taken once results are loaded.
module graph_adjacency_matrix_store #(
    parameter int MAX_VERTICES = gams_pkg::MAX_VERTICES_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [2:0]         mode,
    input  logic signed [31:0] vertex_value,
    input  logic signed [31:0] other_value,
    input  logic signed [6:0]  index_a,
    input  logic signed [6:0]  index_b,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [1:0]         status,
    output logic signed [6:0]  found_index,
    output logic signed [31:0] neighbor_value,
    output logic               neighbor_valid,
    output logic               adjacent,
    output logic [6:0]         vertex_count,
    output logic               last
);
    import gams_pkg::*;

    localparam int N  = MAX_VERTICES;
    localparam int IW = $clog2(N);
    localparam int CW = $clog2(N + 1);

    // Close the gap at bit x: bits above x move down one place
    function automatic logic [N-1:0] squeeze(input logic [N-1:0] r, input logic [IW-1:0] x);
        logic [N-1:0] low;
        logic [N-1:0] hi;
        low = (N'(1) << x) - N'(1);
        hi  = ((r >> x) >> 1) << x;
        return (r & low) | hi;
    endfunction

    // Storage
    logic [31:0]  val_mem [N];
    logic [N-1:0] row_mem [N];
    logic [31:0]  val_rdata;
    logic [N-1:0] row_rdata;

    logic          val_we, val_re, row_we, row_re;
    logic [IW-1:0] val_waddr, val_raddr, row_waddr, row_raddr;
    logic [31:0]   val_wdata;
    logic [N-1:0]  row_wdata;

    // Control and working registers
    state_t            state_reg, state_next;
    logic [CW-1:0]     total_reg, total_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic              chk_v_reg, chk_v_next;
    logic [IW-1:0]     chk_idx_reg, chk_idx_next;
    logic [31:0]       key_reg, key_next;
    logic              phase_reg, phase_next;
    logic              p_ok_reg, p_ok_next;
    logic [IW-1:0]     p_idx_reg, p_idx_next;
    logic [IW-1:0]     q_idx_reg, q_idx_next;
    logic              wr_v_reg, wr_v_next;
    logic [IW-1:0]     wr_idx_reg, wr_idx_next;
    logic [N-1:0]      mask_reg, mask_next;
    status_t           res_status_reg, res_status_next;
    logic signed [6:0] res_found_reg, res_found_next;
    logic              res_adj_reg, res_adj_next;

    // Latched item
    mode_t             mode_reg;
    logic [31:0]       va_reg, vb_reg;
    logic [6:0]        ia_reg, ib_reg;

    // Output register
    logic              out_valid_reg;
    logic [1:0]        out_status_reg;
    logic signed [6:0] out_found_reg;
    logic [31:0]       out_nval_reg;
    logic              out_nvalid_reg, out_adj_reg, out_last_reg;
    logic [6:0]        out_count_reg;

    logic              out_ld;
    logic [1:0]        ld_status;
    logic signed [6:0] ld_found;
    logic [31:0]       ld_nval;
    logic              ld_nvalid, ld_adj, ld_last;

    logic              in_accept, out_free;
    logic              a_ok, b_ok;
    logic [IW-1:0]     ia_idx, ib_idx;
    logic              hit, scan_done;
    logic [IW-1:0]     pos;
    logic [CW-1:0]     cnt_inc;

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;

    assign ia_idx  = ia_reg[IW-1:0];
    assign ib_idx  = ib_reg[IW-1:0];
    assign a_ok    = !ia_reg[6] && (7'(ia_reg[5:0]) < 7'(total_reg));
    assign b_ok    = !ib_reg[6] && (7'(ib_reg[5:0]) < 7'(total_reg));
    assign cnt_inc = cnt_reg + CW'(1);

    // Lowest set bit of the remaining neighbor mask
    always_comb
    begin
        pos = '0;
        for (int i = N - 1; i >= 0; i--)
        begin
            if (mask_reg[i])
            begin
                pos = IW'(i);
            end
        end
    end

    // Latch the item on accept
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            mode_reg <= mode_t'(mode);
            va_reg   <= vertex_value;
            vb_reg   <= other_value;
            ia_reg   <= index_a;
            ib_reg   <= index_b;
        end
    end

    // Memories: one write and one registered read each
    always_ff @(posedge clk)
    begin
        if (val_we)
        begin
            val_mem[val_waddr] <= val_wdata;
        end
        if (val_re)
        begin
            val_rdata <= val_mem[val_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (row_we)
        begin
            row_mem[row_waddr] <= row_wdata;
        end
        if (row_re)
        begin
            row_rdata <= row_mem[row_raddr];
        end
    end

    // Sequencer: next state, memory control and result loading
    always_comb
    begin
        state_next      = state_reg;
        total_next      = total_reg;
        cnt_next        = cnt_reg;
        chk_v_next      = chk_v_reg;
        chk_idx_next    = chk_idx_reg;
        key_next        = key_reg;
        phase_next      = phase_reg;
        p_ok_next       = p_ok_reg;
        p_idx_next      = p_idx_reg;
        q_idx_next      = q_idx_reg;
        wr_v_next       = 1'b0;
        wr_idx_next     = wr_idx_reg;
        mask_next       = mask_reg;
        res_status_next = res_status_reg;
        res_found_next  = res_found_reg;
        res_adj_next    = res_adj_reg;

        val_we = 1'b0; val_waddr = '0; val_wdata = '0; val_re = 1'b0; val_raddr = '0;
        row_we = 1'b0; row_waddr = '0; row_wdata = '0; row_re = 1'b0; row_raddr = '0;

        out_ld    = 1'b0;
        ld_status = 2'(STAT_OK);
        ld_found  = NO_INDEX;
        ld_nval   = '0;
        ld_nvalid = 1'b0;
        ld_adj    = 1'b0;
        ld_last   = 1'b1;

        hit       = 1'b0;
        scan_done = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = ST_DISP;
                end
            end

            ST_DISP:
            begin
                res_status_next = STAT_OK;
                res_found_next  = NO_INDEX;
                res_adj_next    = 1'b0;
                cnt_next        = '0;
                chk_v_next      = 1'b0;
                phase_next      = 1'b0;
                key_next        = va_reg;
                case (mode_reg)
                    MODE_ADD_VERTEX:
                    begin
                        state_next = ST_RESP;
                        if (total_reg == CW'(N))
                        begin
                            res_status_next = STAT_FULL;
                        end
                        else
                        begin
                            // Columns at or above the count are always zero
                            val_we     = 1'b1;
                            val_waddr  = total_reg[IW-1:0];
                            val_wdata  = va_reg;
                            row_we     = 1'b1;
                            row_waddr  = total_reg[IW-1:0];
                            row_wdata  = '0;
                            total_next = total_reg + CW'(1);
                        end
                    end
                    MODE_DEL_VERTEX:
                    begin
                        if (a_ok)
                        begin
                            state_next = ST_REM;
                        end
                        else
                        begin
                            res_status_next = STAT_BAD_INDEX;
                            state_next      = ST_RESP;
                        end
                    end
                    MODE_ADD_EDGE, MODE_DEL_EDGE:
                    begin
                        if (a_ok && b_ok && ia_reg != ib_reg)
                        begin
                            row_re     = 1'b1;
                            row_raddr  = ia_idx;
                            state_next = ST_EDGE_A;
                        end
                        else
                        begin
                            res_status_next = STAT_BAD_INDEX;
                            state_next      = ST_RESP;
                        end
                    end
                    MODE_FIND, MODE_IS_ADJ:
                    begin
                        state_next = ST_SCAN;
                    end
                    MODE_LIST_ADJ:
                    begin
                        if (a_ok)
                        begin
                            row_re     = 1'b1;
                            row_raddr  = ia_idx;
                            state_next = ST_LIST_LD;
                        end
                        else
                        begin
                            res_status_next = STAT_BAD_INDEX;
                            state_next      = ST_RESP;
                        end
                    end
                    default:
                    begin
                        res_status_next = STAT_BAD_MODE;
                        state_next      = ST_RESP;
                    end
                endcase
            end

            // Edge: modify row a, fetch row b
            ST_EDGE_A:
            begin
                row_we    = 1'b1;
                row_waddr = ia_idx;
                row_wdata = (mode_reg == MODE_ADD_EDGE) ? (row_rdata | (N'(1) << ib_idx))
                                                        : (row_rdata & ~(N'(1) << ib_idx));
                row_re     = 1'b1;
                row_raddr  = ib_idx;
                state_next = ST_EDGE_B;
            end

            ST_EDGE_B:
            begin
                row_we    = 1'b1;
                row_waddr = ib_idx;
                row_wdata = (mode_reg == MODE_ADD_EDGE) ? (row_rdata | (N'(1) << ia_idx))
                                                        : (row_rdata & ~(N'(1) << ia_idx));
                state_next = ST_RESP;
            end

            // Linear search of the value memory, one read issued and one compared per cycle
            ST_SCAN:
            begin
                if (chk_v_reg && val_rdata == key_reg)
                begin
                    hit       = 1'b1;
                    scan_done = 1'b1;
                    chk_v_next = 1'b0;
                end
                else if (cnt_reg < total_reg)
                begin
                    val_re       = 1'b1;
                    val_raddr    = cnt_reg[IW-1:0];
                    chk_v_next   = 1'b1;
                    chk_idx_next = cnt_reg[IW-1:0];
                    cnt_next     = cnt_reg + CW'(1);
                end
                else
                begin
                    scan_done  = 1'b1;
                    chk_v_next = 1'b0;
                end

                if (scan_done)
                begin
                    if (mode_reg == MODE_FIND)
                    begin
                        res_found_next = hit ? 7'(chk_idx_reg) : NO_INDEX;
                        state_next     = ST_RESP;
                    end
                    else if (!phase_reg)
                    begin
                        p_ok_next  = hit;
                        p_idx_next = chk_idx_reg;
                        phase_next = 1'b1;
                        key_next   = vb_reg;
                        cnt_next   = '0;
                    end
                    else if (p_ok_reg && hit && p_idx_reg != chk_idx_reg)
                    begin
                        row_re     = 1'b1;
                        row_raddr  = p_idx_reg;
                        q_idx_next = chk_idx_reg;
                        state_next = ST_ADJ_RD;
                    end
                    else
                    begin
                        state_next = ST_RESP;
                    end
                end
            end

            ST_ADJ_RD:
            begin
                res_adj_next = row_rdata[q_idx_reg];
                state_next   = ST_RESP;
            end

            ST_LIST_LD:
            begin
                mask_next  = row_rdata;
                state_next = ST_LIST_NEXT;
            end

            ST_LIST_NEXT:
            begin
                if (mask_reg == '0)
                begin
                    state_next = ST_RESP;
                end
                else
                begin
                    val_re     = 1'b1;
                    val_raddr  = pos;
                    mask_next  = mask_reg & ~(N'(1) << pos);
                    state_next = ST_LIST_EMIT;
                end
            end

            ST_LIST_EMIT:
            begin
                if (out_free)
                begin
                    out_ld     = 1'b1;
                    ld_nval    = val_rdata;
                    ld_nvalid  = 1'b1;
                    ld_last    = (mask_reg == '0);
                    state_next = (mask_reg == '0) ? ST_IDLE : ST_LIST_NEXT;
                end
            end

            // Remove: rows below x squeezed in place, later rows and values moved down
            ST_REM:
            begin
                if (cnt_reg < total_reg - CW'(1))
                begin
                    row_re    = 1'b1;
                    row_raddr = (cnt_reg < CW'(ia_idx)) ? cnt_reg[IW-1:0] : cnt_inc[IW-1:0];
                    val_re      = 1'b1;
                    val_raddr   = cnt_inc[IW-1:0];
                    wr_v_next   = 1'b1;
                    wr_idx_next = cnt_reg[IW-1:0];
                    cnt_next    = cnt_reg + CW'(1);
                end
                else if (!wr_v_reg)
                begin
                    total_next = total_reg - CW'(1);
                    state_next = ST_RESP;
                end

                if (wr_v_reg)
                begin
                    row_we    = 1'b1;
                    row_waddr = wr_idx_reg;
                    row_wdata = squeeze(row_rdata, ia_idx);
                    if (wr_idx_reg >= ia_idx)
                    begin
                        val_we    = 1'b1;
                        val_waddr = wr_idx_reg;
                        val_wdata = val_rdata;
                    end
                end
            end

            ST_RESP:
            begin
                if (out_free)
                begin
                    out_ld     = 1'b1;
                    ld_status  = 2'(res_status_reg);
                    ld_found   = res_found_reg;
                    ld_adj     = res_adj_reg;
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            total_reg <= '0;
            chk_v_reg <= 1'b0;
            wr_v_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            total_reg <= total_next;
            chk_v_reg <= chk_v_next;
            wr_v_reg  <= wr_v_next;
        end
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        cnt_reg        <= cnt_next;
        chk_idx_reg    <= chk_idx_next;
        key_reg        <= key_next;
        phase_reg      <= phase_next;
        p_ok_reg       <= p_ok_next;
        p_idx_reg      <= p_idx_next;
        q_idx_reg      <= q_idx_next;
        wr_idx_reg     <= wr_idx_next;
        mask_reg       <= mask_next;
        res_status_reg <= res_status_next;
        res_found_reg  <= res_found_next;
        res_adj_reg    <= res_adj_next;
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_ld)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_ld)
        begin
            out_status_reg <= ld_status;
            out_found_reg  <= ld_found;
            out_nval_reg   <= ld_nval;
            out_nvalid_reg <= ld_nvalid;
            out_adj_reg    <= ld_adj;
            out_last_reg   <= ld_last;
            out_count_reg  <= 7'(total_reg);
        end
    end

    assign out_valid      = out_valid_reg;
    assign status         = out_status_reg;
    assign found_index    = out_found_reg;
    assign neighbor_value = out_nval_reg;
    assign neighbor_valid = out_nvalid_reg;
    assign adjacent       = out_adj_reg;
    assign vertex_count   = out_count_reg;
    assign last           = out_last_reg;

    // Vertex count moves by at most one per cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        total_reg == $past(total_reg) || total_reg == $past(total_reg) + CW'(1) ||
        total_reg == $past(total_reg) - CW'(1))
        else $error("vertex count jumped");

    // A neighbor result carries ok status and no index
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && neighbor_valid |-> status == 2'(STAT_OK) && found_index == NO_INDEX)
        else $error("neighbor result with bad fields");

    // Reported count never exceeds capacity
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> vertex_count <= 7'(N))
        else $error("vertex count above capacity");

endmodule

[verif/tb_graph_adjacency_matrix_store.sv]
// Self-checking testbench for graph_adjacency_matrix_store: random and directed
// graph operations against an internal graph predictor. Depends on gams_pkg and the RTL.
module tb_graph_adjacency_matrix_store;
    timeunit 1ns;
    timeprecision 1ps;
    import gams_pkg::*;

    localparam int NV = MAX_VERTICES_DEF;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [6:0]  found_index;
        logic signed [31:0] neighbor_value;
        logic               neighbor_valid;
        logic               adjacent;
        logic [6:0]         vertex_count;
        logic               last;
    } graph_result_t;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic [2:0]         mode;
    logic signed [31:0] vertex_value;
    logic signed [31:0] other_value;
    logic signed [6:0]  index_a;
    logic signed [6:0]  index_b;
    logic               out_valid;
    logic               out_stall;
    logic [1:0]         status;
    logic signed [6:0]  found_index;
    logic signed [31:0] neighbor_value;
    logic               neighbor_valid;
    logic               adjacent;
    logic [6:0]         vertex_count;
    logic               last;

    // Predictor state
    logic [31:0]   graph_vals [NV];
    logic [NV-1:0] graph_rows [NV];
    int            graph_total;

    graph_result_t expected_results[$];
    int            fail_count;
    int            burst_left;

    graph_adjacency_matrix_store dut (.*);

    // Clock
    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    function automatic int find_value(logic [31:0] v);
        for (int i = 0; i < graph_total; i++)
        begin
            if (graph_vals[i] == v)
                return i;
        end
        return -1;
    endfunction

    function automatic graph_result_t make_result(status_t st);
        graph_result_t r;
        r.status         = st;
        r.found_index    = NO_INDEX;
        r.neighbor_value = '0;
        r.neighbor_valid = 1'b0;
        r.adjacent       = 1'b0;
        r.vertex_count   = 7'(graph_total);
        r.last           = 1'b1;
        return r;
    endfunction

    // Append one expected result item
    function automatic void queue_expected(graph_result_t r);
        expected_results.insert(expected_results.size(), r);
    endfunction

    // Apply one item to the predictor and queue its results
    task automatic predict_graph_op(logic [2:0] m, logic [31:0] va, logic [31:0] vb,
                                    int ia, int ib);
        graph_result_t r;
        int            p;
        int            q;
        int            k;
        logic [NV-1:0] row;
        logic [NV-1:0] low;
        bit            ia_ok;
        bit            ib_ok;
        ia_ok = ia >= 0 && ia < graph_total;
        ib_ok = ib >= 0 && ib < graph_total;
        case (mode_t'(m))
            MODE_ADD_VERTEX:
            begin
                if (graph_total >= NV)
                    r = make_result(STAT_FULL);
                else
                begin
                    graph_vals[graph_total] = va;
                    graph_rows[graph_total] = '0;
                    for (int i = 0; i < graph_total; i++)
                        graph_rows[i][graph_total] = 1'b0;
                    graph_total++;
                    r = make_result(STAT_OK);
                end
                queue_expected(r);
            end
            MODE_DEL_VERTEX:
            begin
                if (!ia_ok)
                    r = make_result(STAT_BAD_INDEX);
                else
                begin
                    for (int i = ia; i + 1 < graph_total; i++)
                    begin
                        graph_vals[i] = graph_vals[i + 1];
                        graph_rows[i] = graph_rows[i + 1];
                    end
                    graph_total--;
                    low = (NV'(1) << ia) - NV'(1);
                    for (int i = 0; i < graph_total; i++)
                        graph_rows[i] = (graph_rows[i] & low)
                                      | ((graph_rows[i] >> (ia + 1)) << ia);
                    r = make_result(STAT_OK);
                end
                queue_expected(r);
            end
            MODE_ADD_EDGE, MODE_DEL_EDGE:
            begin
                if (!ia_ok || !ib_ok || ia == ib)
                    r = make_result(STAT_BAD_INDEX);
                else
                begin
                    graph_rows[ia][ib] = (m == MODE_ADD_EDGE);
                    graph_rows[ib][ia] = (m == MODE_ADD_EDGE);
                    r = make_result(STAT_OK);
                end
                queue_expected(r);
            end
            MODE_FIND:
            begin
                r = make_result(STAT_OK);
                r.found_index = 7'(find_value(va));
                queue_expected(r);
            end
            MODE_LIST_ADJ:
            begin
                if (!ia_ok)
                    queue_expected(make_result(STAT_BAD_INDEX));
                else
                begin
                    row = graph_rows[ia];
                    k = 0;
                    for (int i = 0; i < graph_total; i++)
                    begin
                        if (row[i])
                        begin
                            r = make_result(STAT_OK);
                            r.neighbor_value = graph_vals[i];
                            r.neighbor_valid = 1'b1;
                            r.last = 1'b0;
                            queue_expected(r);
                            k++;
                        end
                    end
                    if (k == 0)
                        queue_expected(make_result(STAT_OK));
                    else
                        expected_results[$].last = 1'b1;
                end
            end
            MODE_IS_ADJ:
            begin
                p = find_value(va);
                q = find_value(vb);
                r = make_result(STAT_OK);
                if (p >= 0 && q >= 0 && p != q)
                    r.adjacent = graph_rows[p][q];
                queue_expected(r);
            end
            default:
                queue_expected(make_result(STAT_BAD_MODE));
        endcase
    endtask

    // Send one item, with bursty gaps between items; valid stays up inside a burst
    task automatic send_item(logic [2:0] m, logic [31:0] va, logic [31:0] vb,
                             logic [6:0] ia, logic [6:0] ib);
        int gap;
        gap = 0;
        if (burst_left == 0)
        begin
            gap        = $urandom_range(0, 6);
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid     <= 1'b1;
        mode         <= m;
        vertex_value <= va;
        other_value  <= vb;
        index_a      <= ia;
        index_b      <= ib;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_graph_op(m, va, vb, int'($signed(ia)), int'($signed(ib)));
        @(negedge clk);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(negedge clk);
        while (expected_results.size() != 0)
            @(negedge clk);
    endtask

    // Small value pool so find and is-adjacent hit repeated values
    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 3))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            default: return 32'($urandom_range(0, 9));
        endcase
    endfunction

    function automatic logic [6:0] pick_index();
        case ($urandom_range(0, 9))
            0: return 7'($urandom);
            1: return NO_INDEX;
            default: return 7'($urandom_range(0, graph_total > 0 ? graph_total : 0));
        endcase
    endfunction

    task automatic test_modes_directed();
        send_item(MODE_FIND, 32'd5, 0, 0, 0);
        send_item(MODE_DEL_VERTEX, 0, 0, 0, 0);
        send_item(MODE_LIST_ADJ, 0, 0, 0, 0);
        send_item(MODE_UNKNOWN, 32'hffff_ffff, 32'hffff_ffff, 7'h7f, 7'h7f);
        for (int i = 0; i < NV; i++)
            send_item(MODE_ADD_VERTEX, (i == 0) ? 32'h8000_0000 :
                      (i == 1) ? 32'h7fff_ffff : 32'(i % 5), 0, 0, 0);
        send_item(MODE_ADD_VERTEX, 32'd99, 0, 0, 0);
        send_item(MODE_ADD_EDGE, 0, 0, 7'sd0, 7'sd15);
        send_item(MODE_ADD_EDGE, 0, 0, 7'sd3, 7'sd3);
        send_item(MODE_ADD_EDGE, 0, 0, 7'sd0, 7'sd16);
        send_item(MODE_IS_ADJ, 32'h8000_0000, 32'd0, 0, 0);
        send_item(MODE_LIST_ADJ, 0, 0, 7'sd0, 0);
    endtask

    task automatic test_full_rows();
        // Star from vertex 0, list, drop vertex 7 and edge 0-14, list, drop 14 and 0
        for (int i = 1; i < graph_total; i++)
            send_item(MODE_ADD_EDGE, 0, 0, 7'sd0, 7'(i));
        send_item(MODE_LIST_ADJ, 0, 0, 7'sd0, 0);
        // Hold off until all expected results have been checked
        wait_drained();
        send_item(MODE_DEL_VERTEX, 0, 0, 7'sd7, 0);
        send_item(MODE_DEL_EDGE, 0, 0, 7'sd0, 7'sd14);
        send_item(MODE_LIST_ADJ, 0, 0, 7'sd0, 0);
        send_item(MODE_DEL_VERTEX, 0, 0, 7'sd14, 0);
        send_item(MODE_DEL_VERTEX, 0, 0, 7'sd0, 0);
    endtask

    task automatic test_random_ops();
        logic [2:0] m;
        for (int n = 0; n < 105; n++)
        begin
            case ($urandom_range(0, 19))
                0, 1, 2, 3:     m = (graph_total < NV) ? MODE_ADD_VERTEX : MODE_DEL_VERTEX;
                4, 5:           m = MODE_DEL_VERTEX;
                6, 7, 8, 9, 10: m = MODE_ADD_EDGE;
                11:             m = MODE_DEL_EDGE;
                12, 13:         m = MODE_FIND;
                14, 15, 16:     m = MODE_LIST_ADJ;
                17, 18:         m = MODE_IS_ADJ;
                default:        m = 3'($urandom);
            endcase
            send_item(m, (n % 10 == 0) ? $urandom : pick_value(),
                      (n % 10 == 5) ? $urandom : pick_value(), pick_index(), pick_index());
        end
    endtask

    // Receiver stall pattern
    always @(negedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else if (($time / 4000) % 3 == 0)
            out_stall <= 1'b0;
        else
            out_stall <= ($urandom_range(0, 3) == 0);
    end

    // Result checker
    always @(posedge clk)
    begin
        graph_result_t exp_r;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_results.size() == 0)
            begin
                $error("unexpected result item");
                fail_count++;
            end
            else
            begin
                exp_r = expected_results.pop_front();
                if (status !== exp_r.status)
                begin
                    $error("status exp %0d got %0d", exp_r.status, status);
                    fail_count++;
                end
                if (found_index !== exp_r.found_index)
                begin
                    $error("found_index exp %0d got %0d", exp_r.found_index, found_index);
                    fail_count++;
                end
                if (neighbor_value !== exp_r.neighbor_value)
                begin
                    $error("neighbor_value exp %0d got %0d", exp_r.neighbor_value,
                           neighbor_value);
                    fail_count++;
                end
                if (neighbor_valid !== exp_r.neighbor_valid)
                begin
                    $error("neighbor_valid exp %0d got %0d", exp_r.neighbor_valid,
                           neighbor_valid);
                    fail_count++;
                end
                if (adjacent !== exp_r.adjacent)
                begin
                    $error("adjacent exp %0d got %0d", exp_r.adjacent, adjacent);
                    fail_count++;
                end
                if (vertex_count !== exp_r.vertex_count)
                begin
                    $error("vertex_count exp %0d got %0d", exp_r.vertex_count, vertex_count);
                    fail_count++;
                end
                if (last !== exp_r.last)
                begin
                    $error("last exp %0d got %0d", exp_r.last, last);
                    fail_count++;
                end
            end
        end
    end

    // Stimulus sequence
    initial
    begin
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        mode         = '0;
        vertex_value = '0;
        other_value  = '0;
        index_a      = '0;
        index_b      = '0;
        graph_total  = 0;
        fail_count   = 0;
        burst_left   = 0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        test_modes_directed();
        test_full_rows();
        test_random_ops();
        wait_drained();
        repeat (60) @(negedge clk);
        if (fail_count == 0 && expected_results.size() == 0)
            $display("tb_graph_adjacency_matrix_store: PASS");
        else
            $display("tb_graph_adjacency_matrix_store: FAIL");
        $finish;
    end

    // Timeout
    initial
    begin
        #3ms;
        $display("tb_graph_adjacency_matrix_store: FAIL");
        $finish;
    end
endmodule
